### rtl/acpu_pkg.sv
// Shared types, codes and constants for the accumulator machine execute block.
`default_nettype none

package acpu_pkg;

    // Widths fixed by the instruction and result formats
    localparam int WORD_W     = 32;
    localparam int PC_W       = 8;
    localparam int OPC_W      = 4;
    localparam int OFS_W      = 7;

    // Default number of data words, and depth of the front-to-back queue
    localparam int DATA_WORDS_DEF = 128;
    localparam int QUEUE_DEPTH    = 2;

    // Opcodes as they arrive on the input channel
    typedef enum logic [OPC_W-1:0] {
        OP_DEC = 4'd0,
        OP_LDI = 4'd1,
        OP_STR = 4'd2,
        OP_XCH = 4'd3,
        OP_JMP = 4'd4,
        OP_JZS = 4'd5,
        OP_JVS = 4'd6,
        OP_ADD = 4'd7,
        OP_SUB = 4'd8,
        OP_HLT = 4'd9,
        OP_LDA = 4'd10
    } t_op;

    // Operation class after decode; bad addresses and unused opcodes become K_NOP
    typedef enum logic [3:0] {
        K_NOP,
        K_CLR,
        K_LDI,
        K_STR,
        K_XCH,
        K_JMP,
        K_JZS,
        K_JVS,
        K_ADD,
        K_SUB,
        K_HLT,
        K_LDA
    } t_kind;

    // Input beat
    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic [PC_W-1:0]          target_address;
        logic signed [WORD_W-1:0] immediate_value;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [PC_W-1:0]          program_counter;
        logic signed [WORD_W-1:0] accumulator;
        logic signed [WORD_W-1:0] data_register;
        logic                     zero_flag;
        logic                     overflow_flag;
        logic                     halted;
    } t_out_beat;

    // Decoded instruction held in the queue
    typedef struct packed {
        t_kind             kind;
        logic [OFS_W-1:0]  ofs;
        logic [PC_W-1:0]   target;
        logic [WORD_W-1:0] imm;
    } t_uop;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        logic full;
        t_uop head;
    } t_q_status;

endpackage

`default_nettype wire

### rtl/acpu_front.sv
// Front end: accepts instruction beats and classifies them into queue entries.
`default_nettype none

module acpu_front
    import acpu_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
) (
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_beat i_in_beat,
    input  wire logic     i_clearing,
    input  wire logic     i_q_full,
    output logic          o_push,
    output t_uop          o_uop
);

    localparam logic [WORD_W-1:0] WORDS_U = WORD_W'(DATA_WORDS);

    logic             mem_ok;
    logic [OFS_W-1:0] ofs;
    t_kind            kind;

    // Hold off new beats while the store is being cleared or the queue is full
    assign o_in_stall = i_clearing || i_q_full;
    assign o_push     = i_in_valid && !o_in_stall;

    // Check the data address: upper half of the space and inside the store
    assign ofs    = i_in_beat.target_address[OFS_W-1:0];
    assign mem_ok = i_in_beat.target_address[PC_W-1]
                    && ({{(WORD_W-OFS_W){1'b0}}, ofs} < WORDS_U);

    // Classify the opcode; memory ops with a bad address drop to no-op
    always_comb begin
        case (t_op'(i_in_beat.opcode))
            OP_DEC:  kind = mem_ok ? K_CLR : K_NOP;
            OP_LDI:  kind = K_LDI;
            OP_STR:  kind = mem_ok ? K_STR : K_NOP;
            OP_XCH:  kind = K_XCH;
            OP_JMP:  kind = K_JMP;
            OP_JZS:  kind = K_JZS;
            OP_JVS:  kind = K_JVS;
            OP_ADD:  kind = K_ADD;
            OP_SUB:  kind = K_SUB;
            OP_HLT:  kind = K_HLT;
            OP_LDA:  kind = mem_ok ? K_LDA : K_NOP;
            default: kind = K_NOP;
        endcase
    end

    assign o_uop.kind   = kind;
    assign o_uop.ofs    = ofs;
    assign o_uop.target = i_in_beat.target_address;
    assign o_uop.imm    = i_in_beat.immediate_value;

endmodule

`default_nettype wire

### rtl/acpu_queue.sv
// Short queue of decoded instructions between front end and back end.
`default_nettype none

module acpu_queue
    import acpu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_uop i_uop,
    input  wire logic i_pop,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_uop             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    // Advance pointers with wrap, track occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write the incoming entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_uop;
        end
    end

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.head  = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

### rtl/acpu_back.sv
// Back end: data store read, execute stage, machine state and result register.
`default_nettype none

module acpu_back
    import acpu_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    localparam int IDX_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DATA_WORDS - 1);

    // Data store
    logic [WORD_W-1:0] r_store [DATA_WORDS];

    // Clearing pass after reset
    logic              r_clearing;
    logic [IDX_W-1:0]  r_clr_idx;

    // Architectural state
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_b,   n_b;
    logic              r_z,   n_z;
    logic              r_v,   n_v;
    logic [PC_W-1:0]   r_pc,  n_pc;
    logic              r_halt, n_halt;

    // Execute stage
    logic              r_x2_valid;
    t_uop              r_x2;
    logic [WORD_W-1:0] r_rdata;
    logic              r_byp;
    logic [WORD_W-1:0] r_byp_data;

    // Result register
    logic              r_out_valid;
    t_out_beat         r_out;

    logic              exec_en;
    logic              take;
    logic [IDX_W+OFS_W-1:0] head_wide;
    logic [IDX_W+OFS_W-1:0] x2_wide;
    logic [IDX_W-1:0]  head_idx;
    logic [IDX_W-1:0]  x2_idx;
    logic              st_we;
    logic [WORD_W-1:0] st_wdata;
    logic [WORD_W-1:0] load_data;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] diff;
    logic              advance;

    // Map address offsets onto store indexes
    assign head_wide = {{IDX_W{1'b0}}, i_q.head.ofs};
    assign x2_wide   = {{IDX_W{1'b0}}, r_x2.ofs};
    assign head_idx  = head_wide[IDX_W-1:0];
    assign x2_idx    = x2_wide[IDX_W-1:0];

    // Execute when the result register is free or draining this cycle
    assign exec_en = r_x2_valid && (!r_out_valid || !i_out_stall);
    assign take    = i_q.valid && !r_clearing && (!r_x2_valid || exec_en);
    assign o_pop   = take;

    // Store write from the execute stage
    assign st_we    = exec_en && !r_halt && ((r_x2.kind == K_CLR) || (r_x2.kind == K_STR));
    assign st_wdata = (r_x2.kind == K_STR) ? r_acc : '0;

    // Sweep the store to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_clearing = r_clearing;

    // Store port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_store[r_clr_idx] <= '0;
        end else if (st_we) begin
            r_store[x2_idx] <= st_wdata;
        end
        if (take) begin
            r_rdata <= r_store[head_idx];
        end
    end

    // Catch a store that lands on the word being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byp      <= st_we && (x2_idx == head_idx);
            r_byp_data <= st_wdata;
            r_x2       <= i_q.head;
        end
    end

    assign load_data = r_byp ? r_byp_data : r_rdata;
    assign sum       = r_acc + r_b;
    assign diff      = r_acc - r_b;

    // Compute the next machine state for the instruction in execute
    always_comb begin
        n_acc   = r_acc;
        n_b     = r_b;
        n_z     = r_z;
        n_v     = r_v;
        n_pc    = r_pc;
        n_halt  = r_halt;
        advance = 1'b1;
        if (!r_halt) begin
            case (r_x2.kind)
                K_LDI: n_acc = r_x2.imm;
                K_XCH: begin
                    n_acc = r_b;
                    n_b   = r_acc;
                end
                K_JMP: begin
                    n_pc    = r_x2.target;
                    advance = 1'b0;
                end
                K_JZS: begin
                    if (r_z) begin
                        n_pc    = r_x2.target;
                        advance = 1'b0;
                    end
                end
                K_JVS: begin
                    if (r_v) begin
                        n_pc    = r_x2.target;
                        advance = 1'b0;
                    end
                end
                K_ADD: begin
                    n_acc = sum;
                    n_z   = (sum == '0);
                    n_v   = (r_acc[WORD_W-1] == r_b[WORD_W-1])
                            && (sum[WORD_W-1] != r_acc[WORD_W-1]);
                end
                K_SUB: begin
                    n_acc = diff;
                    n_z   = (diff == '0);
                    n_v   = (r_acc[WORD_W-1] != r_b[WORD_W-1])
                            && (diff[WORD_W-1] != r_acc[WORD_W-1]);
                end
                K_HLT: begin
                    n_halt  = 1'b1;
                    advance = 1'b0;
                end
                K_LDA: n_acc = load_data;
                default: ;
            endcase
            if (advance) begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    // Commit machine state and move the execute stage along
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_b        <= '0;
            r_z        <= 1'b0;
            r_v        <= 1'b0;
            r_pc       <= '0;
            r_halt     <= 1'b0;
            r_x2_valid <= 1'b0;
        end else begin
            if (exec_en) begin
                r_acc  <= n_acc;
                r_b    <= n_b;
                r_z    <= n_z;
                r_v    <= n_v;
                r_pc   <= n_pc;
                r_halt <= n_halt;
            end
            if (take) begin
                r_x2_valid <= 1'b1;
            end else if (exec_en) begin
                r_x2_valid <= 1'b0;
            end
        end
    end

    // Load the result beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_out.program_counter <= n_pc;
            r_out.accumulator     <= n_acc;
            r_out.data_register   <= n_b;
            r_out.zero_flag       <= n_z;
            r_out.overflow_flag   <= n_v;
            r_out.halted          <= n_halt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

### rtl/accumulator_cpu_execute.sv
// Top level of the accumulator machine execute block.
//
// Executes one instruction per input beat and returns one result beat with the
// machine state after it. Sustained rate is one instruction per clock while the
// output side is not stalled: the front end decodes into a two-entry queue, the
// back end registers its data store read ahead of execution and forwards a
// store to the same word, so a load right after a store sees the new value. An
// accepted instruction is written into the queue, then taken from the queue
// with its store read, then executed into the result register; a stall on the
// output side holds it. After reset the data store is cleared one word per
// clock, during which input beats are stalled. Data addresses 128 and up map
// onto store words from 0.
`default_nettype none

module accumulator_cpu_execute
    import acpu_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    logic      push;
    t_uop      uop;
    logic      pop;
    logic      clearing;
    t_q_status q_status;

    acpu_front #(
        .DATA_WORDS (DATA_WORDS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_clearing (clearing),
        .i_q_full   (q_status.full),
        .o_push     (push),
        .o_uop      (uop)
    );

    acpu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_uop    (uop),
        .i_pop    (pop),
        .o_status (q_status)
    );

    acpu_back #(
        .DATA_WORDS (DATA_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_status),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire
